// ===== design/swlpc_pkg.sv =====
// Shared types and constants for the stopwatch lap/pause controller.
`timescale 1ns / 1ps

package swlpc_pkg;

    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [HOLD_W-1:0] HOLD_RESET_MS = 16'd2000;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_LAP   = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_RESET = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_PRESS   = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        HOLD_SHORT  = 2'd0,
        HOLD_MEDIUM = 2'd1,
        HOLD_LONG   = 2'd2
    } hold_class_t;

endpackage

// ===== design/stopwatch_lap_pause_control.sv =====
// Stopwatch lap/pause controller: input register, state update, result register.
// The state update is one pass of compare/subtract logic between input reg and result reg.
// Throughput: one request per cycle while the output is not stalled (m_tready).
// A held result does not block intake until both the input and result registers are full.
// Reset (aresetn low, synchronous): mode idle, all stamps and pause sums zero,
// first lap pending, hold interval back to 2000 ms.
`timescale 1ns / 1ps

module stopwatch_lap_pause_control (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write: hold_interval_ms
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swlpc_pkg::HOLD_W-1:0]       cfg_data,
    // s_tdata: now_ms[31:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swlpc_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser: func[1:0]
    input  logic [swlpc_pkg::IN_USER_W-1:0]    s_tuser,
    // m_tdata: mode[2:0], elapsed_ms[34:3], lap_ms[66:35], lap_visible[67], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swlpc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import swlpc_pkg::*;

    localparam int unsigned PAD_W = OUT_DATA_W - (3 + 2 * STAMP_W + 1);

    logic [HOLD_W-1:0]      hold_iv_reg;

    logic                   in_valid_reg;
    func_t                  in_func_reg;
    logic [STAMP_W-1:0]     in_now_reg;

    mode_t                  mode_reg, mode_next;
    logic [STAMP_W-1:0]     start_reg, start_next;
    logic [STAMP_W-1:0]     base_reg, base_next;        // start stamp plus total pause
    logic [STAMP_W-1:0]     sampled_reg, sampled_next;
    logic [STAMP_W-1:0]     pause_stamp_reg, pause_stamp_next;
    logic [STAMP_W-1:0]     psl_reg, psl_next;          // pause since last lap
    logic [STAMP_W-1:0]     last_lap_reg, last_lap_next;
    logic [STAMP_W-1:0]     lap_reg, lap_next;
    logic                   opening_lap_reg, opening_lap_next;
    logic                   pause_seen_reg, pause_seen_next;
    logic [STAMP_W-1:0]     press_stamp_reg, press_stamp_next;
    logic                   press_active_reg, press_active_next;
    logic                   lap_shown_reg, lap_shown_next;

    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    logic                   advance;
    logic [HOLD_W-1:0]      hold_iv;
    logic [STAMP_W-1:0]     hold_ms;
    logic [STAMP_W-1:0]     span;
    logic [STAMP_W-1:0]     lap_ref;
    logic [STAMP_W-1:0]     lap_off;
    hold_class_t            hold_class;
    logic [STAMP_W-1:0]     elapsed;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // A zero interval acts as one.
    assign hold_iv = (hold_iv_reg == '0) ? HOLD_W'(1) : hold_iv_reg;
    assign hold_ms = in_now_reg - press_stamp_reg;
    assign span    = in_now_reg - pause_stamp_reg;
    assign lap_ref = opening_lap_reg ? start_reg : last_lap_reg;
    assign lap_off = pause_seen_reg ? psl_reg : '0;

    always_comb begin
        if (!press_active_reg || hold_ms < STAMP_W'(hold_iv)) begin
            hold_class = HOLD_SHORT;
        end else if (hold_ms < {{(STAMP_W-HOLD_W-1){1'b0}}, hold_iv, 1'b0}) begin
            hold_class = HOLD_MEDIUM;
        end else begin
            hold_class = HOLD_LONG;
        end
    end

    always_comb begin
        mode_next         = mode_reg;
        start_next        = start_reg;
        base_next         = base_reg;
        sampled_next      = sampled_reg;
        pause_stamp_next  = pause_stamp_reg;
        psl_next          = psl_reg;
        last_lap_next     = last_lap_reg;
        lap_next          = lap_reg;
        opening_lap_next  = opening_lap_reg;
        pause_seen_next   = pause_seen_reg;
        press_stamp_next  = press_stamp_reg;
        press_active_next = press_active_reg;
        lap_shown_next    = lap_shown_reg;

        case (in_func_reg)
            FUNC_TICK: begin
                unique case (mode_reg)
                    MODE_IDLE, MODE_PAUSE: begin
                    end
                    MODE_RUN: begin
                        sampled_next = in_now_reg;
                    end
                    MODE_LAP: begin
                        // settle the pending lap against the previous sample
                        lap_next         = sampled_reg - lap_ref - lap_off;
                        last_lap_next    = sampled_reg;
                        opening_lap_next = 1'b0;
                        pause_seen_next  = 1'b0;
                        lap_shown_next   = 1'b1;
                        sampled_next     = in_now_reg;
                        mode_next        = MODE_RUN;
                    end
                    MODE_RESET: begin
                        lap_shown_next = 1'b0;
                    end
                    default: begin
                        mode_next = MODE_RESET;
                    end
                endcase
            end
            FUNC_PRESS: begin
                press_stamp_next  = in_now_reg;
                press_active_next = 1'b1;
            end
            FUNC_RELEASE: begin
                press_active_next = 1'b0;
                case (hold_class)
                    HOLD_SHORT: begin
                        if (mode_reg == MODE_IDLE) begin
                            mode_next  = MODE_RUN;
                            start_next = in_now_reg;
                            base_next  = in_now_reg - (start_reg - base_reg);
                        end else if (mode_reg == MODE_RUN) begin
                            mode_next = MODE_LAP;
                        end else if (mode_reg == MODE_RESET) begin
                            start_next       = in_now_reg;
                            base_next        = in_now_reg;
                            psl_next         = '0;
                            last_lap_next    = '0;
                            lap_shown_next   = 1'b0;
                            opening_lap_next = 1'b1;
                            pause_seen_next  = 1'b0;
                            mode_next        = MODE_RUN;
                        end
                    end
                    HOLD_MEDIUM: begin
                        if (mode_reg == MODE_RUN) begin
                            pause_stamp_next = sampled_reg;
                            mode_next        = MODE_PAUSE;
                        end else if (mode_reg == MODE_PAUSE) begin
                            base_next       = base_reg + span;
                            psl_next        = pause_seen_reg ? psl_reg + span : span;
                            pause_seen_next = 1'b1;
                            mode_next       = MODE_RUN;
                        end
                    end
                    default: begin
                        if (mode_reg == MODE_RUN) begin
                            mode_next = MODE_RESET;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // elapsed = sampled - start - total pause, with base = start + total pause
    assign elapsed = sampled_next - base_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_iv_reg      <= HOLD_RESET_MS;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            mode_reg         <= MODE_IDLE;
            start_reg        <= '0;
            base_reg         <= '0;
            sampled_reg      <= '0;
            pause_stamp_reg  <= '0;
            psl_reg          <= '0;
            last_lap_reg     <= '0;
            lap_reg          <= '0;
            opening_lap_reg  <= 1'b1;
            pause_seen_reg   <= 1'b0;
            press_stamp_reg  <= '0;
            press_active_reg <= 1'b0;
            lap_shown_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                hold_iv_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg      <= 1'b1;
                mode_reg         <= mode_next;
                start_reg        <= start_next;
                base_reg         <= base_next;
                sampled_reg      <= sampled_next;
                pause_stamp_reg  <= pause_stamp_next;
                psl_reg          <= psl_next;
                last_lap_reg     <= last_lap_next;
                lap_reg          <= lap_next;
                opening_lap_reg  <= opening_lap_next;
                pause_seen_reg   <= pause_seen_next;
                press_stamp_reg  <= press_stamp_next;
                press_active_reg <= press_active_next;
                lap_shown_reg    <= lap_shown_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold the input while stalled, load the result on advance
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= func_t'(s_tuser);
            in_now_reg  <= s_tdata;
        end
        if (advance) begin
            m_data_reg <= {{PAD_W{1'b0}}, lap_shown_next, lap_next, elapsed, mode_next};
        end
    end

endmodule
